[hw/rtl/vcqe_pkg.sv]
// Shared types and constants for the coefficient quantizer with end-of-block tracking.
`default_nettype none
package vcqe_pkg;

  localparam int COEF_W           = 16;
  localparam int POS_W            = 10;
  localparam int EOB_W            = 11;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int MAX_BLOCK_COEFFS = 1024;

  localparam logic [EOB_W-1:0] EOB_CAP = EOB_W'(MAX_BLOCK_COEFFS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_BIN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDING    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_MULT  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_SHIFT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_DEQUANT     = CFG_IDX_W'(4);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[hw/rtl/vcqe_ctrl.sv]
// Sequencing controller: accept, three shared-multiplier steps, result emit.
`default_nettype none
module vcqe_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire vcqe_pkg::sts_t sts,
  output vcqe_pkg::cmd_t     cmd
);
  import vcqe_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL1;
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_MUL2: cmd.mul2 = 1'b1;
      ST_MUL3: cmd.mul3 = 1'b1;
      ST_EMIT: cmd.emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/vcqe_datapath.sv]
// Quantizer datapath: parameter registers, shared 16x16 multiplier, EOB tracking, output register.
`default_nettype none
module vcqe_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [vcqe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [vcqe_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic signed [vcqe_pkg::COEF_W-1:0]  coefficient,
  input  wire logic [vcqe_pkg::POS_W-1:0]          scan_position,
  input  wire logic                                block_first,
  input  wire logic                                block_last,
  input  wire vcqe_pkg::cmd_t                      cmd,
  output vcqe_pkg::sts_t                           sts,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [vcqe_pkg::COEF_W-1:0]       quantized,
  output logic signed [vcqe_pkg::COEF_W-1:0]       dequantized,
  output logic [vcqe_pkg::EOB_W-1:0]               end_of_block,
  output logic                                     result_last
);
  import vcqe_pkg::*;

  logic [CFG_DATA_W-1:0] zero_bin_pair, rounding_pair, quant_mult_pair;
  logic [CFG_DATA_W-1:0] quant_shift_pair, dequant_pair;
  logic [EOB_W-1:0]      running_eob;

  // per-item work registers
  logic signed [COEF_W-1:0] s_val, t_val, q_val, dq_val;
  logic signed [COEF_W-1:0] quant_h, shift_h, deq_h;
  logic                     neg, kept_nz, first_r, last_r;
  logic [POS_W-1:0]         pos_r;

  // input side selection
  logic signed [COEF_W-1:0] zbin_sel, round_sel, abs_c, zb_m1;
  logic signed [COEF_W:0]   sum_ext;
  logic signed [COEF_W-1:0] s_sat;
  logic                     kept;

  always_comb begin
    zbin_sel  = block_first ? zero_bin_pair[COEF_W-1:0] : zero_bin_pair[2*COEF_W-1:COEF_W];
    round_sel = block_first ? rounding_pair[COEF_W-1:0] : rounding_pair[2*COEF_W-1:COEF_W];
    abs_c     = coefficient[COEF_W-1] ? -coefficient : coefficient;
    zb_m1     = zbin_sel - COEF_W'(1);
    kept      = abs_c > zb_m1;
    sum_ext   = {abs_c[COEF_W-1], abs_c} + {round_sel[COEF_W-1], round_sel};
    if (sum_ext > (COEF_W+1)'(signed'(32767)))
      s_sat = 16'sh7fff;
    else if (sum_ext < -(COEF_W+1)'(signed'(32768)))
      s_sat = 16'sh8000;
    else
      s_sat = sum_ext[COEF_W-1:0];
  end

  // one multiplier, operands picked by the active step
  logic signed [COEF_W-1:0]   mul_a, mul_b;
  logic signed [2*COEF_W-1:0] prod;
  logic signed [COEF_W-1:0]   prod_hi, q_mag;

  always_comb begin
    mul_a = s_val;
    mul_b = quant_h;
    if (cmd.mul2) begin
      mul_a = t_val;
      mul_b = shift_h;
    end else if (cmd.mul3) begin
      mul_a = q_val;
      mul_b = deq_h;
    end
    prod    = mul_a * mul_b;
    prod_hi = prod[2*COEF_W-1:COEF_W];
    q_mag   = neg ? -prod_hi : prod_hi;
  end

  // end-of-block update at emit
  logic [EOB_W-1:0] cand, eob_base, eob_new;

  always_comb begin
    cand = EOB_W'(pos_r) + EOB_W'(1);
    if (cand > EOB_CAP) cand = EOB_CAP;
    eob_base = first_r ? '0 : running_eob;
    eob_new  = ((dq_val != '0) && (cand > eob_base)) ? cand : eob_base;
  end

  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_bin_pair    <= '0;
      rounding_pair    <= '0;
      quant_mult_pair  <= '0;
      quant_shift_pair <= '0;
      dequant_pair     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ZERO_BIN:    zero_bin_pair    <= cfg_data;
        REG_ROUNDING:    rounding_pair    <= cfg_data;
        REG_QUANT_MULT:  quant_mult_pair  <= cfg_data;
        REG_QUANT_SHIFT: quant_shift_pair <= cfg_data;
        REG_DEQUANT:     dequant_pair     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_val   <= s_sat;
      neg     <= coefficient[COEF_W-1];
      kept_nz <= kept && (coefficient != '0);
      first_r <= block_first;
      last_r  <= block_last;
      pos_r   <= scan_position;
      quant_h <= block_first ? quant_mult_pair[COEF_W-1:0]
                             : quant_mult_pair[2*COEF_W-1:COEF_W];
      shift_h <= block_first ? quant_shift_pair[COEF_W-1:0]
                             : quant_shift_pair[2*COEF_W-1:COEF_W];
      deq_h   <= block_first ? dequant_pair[COEF_W-1:0]
                             : dequant_pair[2*COEF_W-1:COEF_W];
    end
    if (cmd.mul1) t_val <= prod_hi + s_val;
    if (cmd.mul2) q_val <= kept_nz ? q_mag : '0;
    if (cmd.mul3) dq_val <= prod[COEF_W-1:0];
    if (cmd.emit) begin
      quantized    <= q_val;
      dequantized  <= dq_val;
      end_of_block <= last_r ? eob_new : '0;
      result_last  <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_eob <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.emit) begin
        running_eob <= last_r ? '0 : eob_new;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid   <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/video_coeff_quantizer_eob.sv]
// Top level of the coefficient quantizer with end-of-block tracking.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------------
//   input    | in_valid / in_stall    | coefficient, scan_position, block_first/last
//   output   | out_valid / out_stall  | quantized, dequantized, end_of_block, result_last
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each request passes through accept, three steps through the single shared
// 16x16 multiplier, then the emit into the output register.
// A result held in the output register under out_stall does not block the next
// request from entering; it only holds that request at its emit step.
// rst is synchronous: configuration registers zero, running end-of-block zero, output empty.
// cfg_ready is always high.
`default_nettype none
module video_coeff_quantizer_eob (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [vcqe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [vcqe_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [vcqe_pkg::COEF_W-1:0]  coefficient,
  input  wire logic [vcqe_pkg::POS_W-1:0]          scan_position,
  input  wire logic                                block_first,
  input  wire logic                                block_last,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [vcqe_pkg::COEF_W-1:0]       quantized,
  output logic signed [vcqe_pkg::COEF_W-1:0]       dequantized,
  output logic [vcqe_pkg::EOB_W-1:0]               end_of_block,
  output logic                                     result_last
);
  import vcqe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  vcqe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vcqe_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .coefficient   (coefficient),
    .scan_position (scan_position),
    .block_first   (block_first),
    .block_last    (block_last),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .quantized     (quantized),
    .dequantized   (dequantized),
    .end_of_block  (end_of_block),
    .result_last   (result_last)
  );

endmodule
`default_nettype wire

[tb/tb_video_coeff_quantizer_eob.sv]
// Self-checking testbench for the coefficient quantizer with end-of-block tracking.
`default_nettype none
module tb_video_coeff_quantizer_eob;
  import vcqe_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int NUM_CFG_REGS = REG_DEQUANT + 1;
  localparam int SPARE_FIRST  = REG_DEQUANT + 1;
  localparam int SPARE_LAST   = (1 << CFG_IDX_W) - 1;
  localparam int MAX_WAIT     = 17;
  localparam int PHASE_ITEMS  = 160;
  localparam int NUM_PHASES   = 6;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE       = 8;
  localparam int LONG_BLOCK   = 256;

  typedef enum logic [2:0] {
    SET_ZERO,
    SET_TYPICAL,
    SET_ALL_ONES,
    SET_MAX_POS,
    SET_MIN_NEG,
    SET_RANDOM_REAL,
    SET_RANDOM_FULL
  } setting_t;

  typedef struct packed {
    logic [COEF_W-1:0] level;
    logic [COEF_W-1:0] recon;
    logic [EOB_W-1:0]  eob;
    logic              last;
  } level_t;

  typedef struct packed {
    setting_t          setting;
    logic [COEF_W-1:0] coef;
    logic [POS_W-1:0]  pos;
    logic              first;
    logic              last;
    logic              typed;
    level_t            want;
  } coef_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COEF_W-1:0] coefficient = '0;
  logic [POS_W-1:0] scan_position = '0;
  logic block_first = 1'b0;
  logic block_last = 1'b0;
  logic out_valid;
  logic out_stall;
  logic signed [COEF_W-1:0] quantized;
  logic signed [COEF_W-1:0] dequantized;
  logic [EOB_W-1:0] end_of_block;
  logic result_last;

  logic rx_stall = 1'b0;
  logic hold_req = 1'b0;
  logic pressure_go = 1'b0;
  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;

  logic [CFG_DATA_W-1:0] reg_shadow [NUM_CFG_REGS];
  logic [EOB_W-1:0] eob_track = '0;
  level_t pending_levels [$];
  coef_row_t dir_rows [$];
  int mismatch_count = 0;
  int cycle_count = 0;

  assign out_stall = rx_stall | hold_req;

  always #1 clk = ~clk;

  video_coeff_quantizer_eob DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .coefficient(coefficient), .scan_position(scan_position),
    .block_first(block_first), .block_last(block_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .quantized(quantized), .dequantized(dequantized),
    .end_of_block(end_of_block), .result_last(result_last)
  );

  // Expected level, reconstruction and end-of-block count for one coefficient.
  // Advances the running end-of-block count.
  function automatic level_t quantize_coeff(logic signed [COEF_W-1:0] c, logic [POS_W-1:0] pos,
                                            logic first, logic last);
    logic signed [COEF_W-1:0] zb, rnd, qm, qs, step, zb_less, mag, s16, t16, lvl, rec;
    logic [EOB_W-1:0] cand;
    int sum, prod;
    level_t r;
    if (first) eob_track = '0;
    // DC takes the low halves, AC the high halves
    zb   = first ? reg_shadow[REG_ZERO_BIN][15:0]    : reg_shadow[REG_ZERO_BIN][31:16];
    rnd  = first ? reg_shadow[REG_ROUNDING][15:0]    : reg_shadow[REG_ROUNDING][31:16];
    qm   = first ? reg_shadow[REG_QUANT_MULT][15:0]  : reg_shadow[REG_QUANT_MULT][31:16];
    qs   = first ? reg_shadow[REG_QUANT_SHIFT][15:0] : reg_shadow[REG_QUANT_SHIFT][31:16];
    step = first ? reg_shadow[REG_DEQUANT][15:0]     : reg_shadow[REG_DEQUANT][31:16];
    zb_less = zb - 16'sd1;
    mag = (c < 0) ? -c : c;  // -32768 stays negative
    sum = int'(mag) + int'(rnd);
    if (sum > 32767) sum = 32767;
    else if (sum < -32768) sum = -32768;
    s16 = sum[15:0];
    prod = int'(s16) * int'(qm);
    t16 = prod[31:16] + s16;
    prod = int'(t16) * int'(qs);
    lvl = prod[31:16];
    if (c < 0) lvl = -lvl;
    else if (c == 0) lvl = '0;
    if (!(mag > zb_less)) lvl = '0;
    prod = int'(lvl) * int'(step);
    rec = prod[15:0];
    if (rec != 0) begin
      cand = EOB_W'(pos) + 1'b1;
      if (cand > EOB_CAP) cand = EOB_CAP;
      if (cand > eob_track) eob_track = cand;
    end
    r.level = lvl;
    r.recon = rec;
    r.eob = last ? eob_track : '0;
    r.last = last;
    if (last) eob_track = '0;
    return r;
  endfunction

  function automatic coef_row_t mk_row(setting_t st, int c, int pos, int first, int last,
                                       int typed, int q, int dq, int eob);
    coef_row_t row;
    row.setting = st;
    row.coef = COEF_W'(c);
    row.pos = POS_W'(pos);
    row.first = (first != 0);
    row.last = (last != 0);
    row.typed = (typed != 0);
    row.want.level = COEF_W'(q);
    row.want.recon = COEF_W'(dq);
    row.want.eob = EOB_W'(eob);
    row.want.last = (last != 0);
    return row;
  endfunction

  function automatic logic [COEF_W-1:0] draw_coeff();
    int pick, m;
    pick = $urandom_range(0, 99);
    m = $urandom_range(0, 120);
    if (pick < 10) return '0;
    if (pick < 70) return COEF_W'($urandom_range(0, 1) ? -m : m);
    if (pick < 95) return COEF_W'($urandom);
    case ($urandom_range(0, 2))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'h8001;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic offer_coeff(coef_row_t row);
    int gap;
    level_t lv;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    coefficient = row.coef;
    scan_position = row.pos;
    block_first = row.first;
    block_last = row.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lv = quantize_coeff(row.coef, row.pos, row.first, row.last);
    if (row.typed) lv = row.want;
    pending_levels.push_back(lv);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_DEQUANT) reg_shadow[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain_block();
    in_valid = 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_half(int lo, int hi);
    return 16'($urandom_range(lo, hi));
  endfunction

  task automatic apply_setting(setting_t st);
    logic [CFG_DATA_W-1:0] vals [NUM_CFG_REGS];
    case (st)
      SET_ZERO: foreach (vals[i]) vals[i] = '0;
      SET_TYPICAL: begin
        vals[REG_ZERO_BIN]    = {16'd8, 16'd4};
        vals[REG_ROUNDING]    = {16'd3, 16'd2};
        vals[REG_QUANT_MULT]  = {16'h5555, 16'h4000};
        vals[REG_QUANT_SHIFT] = {16'h4000, 16'h3000};
        vals[REG_DEQUANT]     = {16'd7, 16'd5};
      end
      SET_ALL_ONES: foreach (vals[i]) vals[i] = '1;
      SET_MAX_POS: foreach (vals[i]) vals[i] = 32'h7FFF_7FFF;
      SET_MIN_NEG: foreach (vals[i]) vals[i] = 32'h8000_8000;
      SET_RANDOM_REAL: begin
        vals[REG_ZERO_BIN]    = {rand_half(0, 64), rand_half(0, 64)};
        vals[REG_ROUNDING]    = {rand_half(0, 40), rand_half(0, 40)};
        vals[REG_QUANT_MULT]  = {rand_half(16'h4000, 16'h7FFF), rand_half(16'h4000, 16'h7FFF)};
        vals[REG_QUANT_SHIFT] = {rand_half(16'h0800, 16'h7FFF), rand_half(16'h0800, 16'h7FFF)};
        vals[REG_DEQUANT]     = {rand_half(1, 300), rand_half(1, 300)};
      end
      default: foreach (vals[i]) vals[i] = $urandom;
    endcase
    write_reg(REG_ZERO_BIN, vals[REG_ZERO_BIN]);
    write_reg(REG_ROUNDING, vals[REG_ROUNDING]);
    write_reg(REG_QUANT_MULT, vals[REG_QUANT_MULT]);
    write_reg(REG_QUANT_SHIFT, vals[REG_QUANT_SHIFT]);
    write_reg(REG_DEQUANT, vals[REG_DEQUANT]);
    // indexes past the last register must be dropped
    write_reg(CFG_IDX_W'($urandom_range(SPARE_FIRST, SPARE_LAST)), $urandom);
  endtask

  // Result checker
  always @(posedge clk) begin
    level_t lv;
    if (!rst && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("result with no pending request, quantized", int'(quantized), 0);
      end else begin
        lv = pending_levels.pop_front();
        if (quantized !== lv.level)
          report_mismatch("quantized", int'(quantized), int'($signed(lv.level)));
        if (dequantized !== lv.recon)
          report_mismatch("dequantized", int'(dequantized), int'($signed(lv.recon)));
        if (end_of_block !== lv.eob)
          report_mismatch("end_of_block", int'(end_of_block), int'(lv.eob));
        if (result_last !== lv.last)
          report_mismatch("result_last", int'(result_last), int'(lv.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("video_coeff_quantizer_eob regression: fail");
      $finish;
    end
  end

  // Output side: random wait before each result
  initial begin
    int wait_n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_n = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      rx_stall = (wait_n != 0);
      repeat (wait_n) @(negedge clk);
      rx_stall = 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Long output hold while requests keep coming, to back up the input side
  initial begin
    wait (pressure_go);
    @(negedge clk);
    hold_req = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_req = 1'b0;
  end

  initial begin
    setting_t cur;
    coef_row_t row;
    int sent, len;
    logic scrambled;
    foreach (reg_shadow[i]) reg_shadow[i] = '0;

    // setting, coefficient, position, first, last, typed, level, recon, eob
    dir_rows.push_back(mk_row(SET_ZERO, 32767, 0, 1, 1, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_ZERO, -32768, 1023, 0, 1, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_ZERO, -1, 512, 1, 0, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_ZERO, 1, 1, 0, 1, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_TYPICAL, 0, 0, 1, 0, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_TYPICAL, 32767, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_TYPICAL, -32767, 2, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_TYPICAL, 7, 3, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_TYPICAL, 8, 4, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_TYPICAL, -32768, 5, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_TYPICAL, -9, 1023, 0, 1, 0, 0, 0, 0));
    // block opened without a first flag
    dir_rows.push_back(mk_row(SET_TYPICAL, 40, 7, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_TYPICAL, 2, 8, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_TYPICAL, 5, 0, 1, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_TYPICAL, 3, 0, 1, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_ALL_ONES, 32767, 0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_ALL_ONES, -32768, 1, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_ALL_ONES, -5, 1, 1, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_MAX_POS, 32767, 0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_MAX_POS, -32767, 1000, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_MIN_NEG, 32767, 0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_MIN_NEG, -32767, 1, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(SET_MIN_NEG, 0, 2, 1, 1, 1, 0, 0, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    cur = SET_ZERO;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != cur) begin
        drain_block();
        cur = dir_rows[i].setting;
        apply_setting(cur);
      end
      offer_coeff(dir_rows[i]);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_block();
      if (p % 3 == 2) begin
        case ($urandom_range(0, 3))
          0: cur = SET_RANDOM_FULL;
          1: cur = SET_ALL_ONES;
          2: cur = SET_MAX_POS;
          default: cur = SET_MIN_NEG;
        endcase
      end else begin
        cur = SET_RANDOM_REAL;
      end
      apply_setting(cur);
      if (p == 1) pressure_go = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        tx_quiet = ($urandom_range(0, 4) == 0);
        rx_quiet = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) != 0) begin
          // well-formed block: DC first, AC after, last flag closes it
          len = ($urandom_range(0, 49) == 0) ? $urandom_range(65, LONG_BLOCK)
                                             : $urandom_range(1, 48);
          scrambled = ($urandom_range(0, 3) == 0);
          for (int k = 0; k < len; k++) begin
            row = mk_row(cur, int'($signed(draw_coeff())),
                         scrambled ? $urandom_range(0, MAX_BLOCK_COEFFS - 1) : k,
                         int'(k == 0), int'(k == len - 1), 0, 0, 0, 0);
            offer_coeff(row);
          end
          sent += len;
        end else begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++) begin
            row = mk_row(cur, int'($signed(draw_coeff())),
                         $urandom_range(0, MAX_BLOCK_COEFFS - 1),
                         int'($urandom_range(0, 1)), int'($urandom_range(0, 1)), 0, 0, 0, 0);
            offer_coeff(row);
          end
          sent += len;
        end
      end
    end

    in_valid = 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("video_coeff_quantizer_eob regression: pass");
    end else begin
      $display("video_coeff_quantizer_eob regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
